>>> design/sspm_pkg.sv
package sspm_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int RING_DEPTH_DEF  = 4096;
    localparam int LEVEL_W         = SAMPLE_BITS - 1;
    localparam int OCC_W           = 12;
    localparam int RING_FRAMES_W   = 13;
    localparam int DECAY_W         = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 15;
    localparam int RING_FRAMES_RST = 4096;
    localparam logic [DECAY_W-1:0] DECAY_RST = 15'd27853;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF = 2'd1;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_EOB   = 2'd2,
        REQ_NOP   = 2'd3
    } req_type_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic    wr;
        logic    eob;
        sample_t left;
        sample_t right;
    } mtr_req_t;

    // |x| saturated to the positive full scale
    function automatic level_t abs_sat(input sample_t x);
        logic [SAMPLE_BITS-1:0] neg;
        begin
            neg = ~x + 1'b1;
            if (!x[SAMPLE_BITS-1])
                abs_sat = x[LEVEL_W-1:0];
            else if (neg[SAMPLE_BITS-1])
                abs_sat = '1;
            else
                abs_sat = neg[LEVEL_W-1:0];
        end
    endfunction

endpackage

>>> design/sspm_if.sv
interface sspm_req_if
    import sspm_pkg::*;
();
    logic      valid;
    logic      ready;
    req_type_t req_type;
    sample_t   left_sample;
    sample_t   right_sample;
    logic      is_mono;

    modport source (output valid, req_type, left_sample, right_sample, is_mono,
                    input ready);
    modport sink   (input valid, req_type, left_sample, right_sample, is_mono,
                    output ready);
endinterface

interface sspm_rsp_if
    import sspm_pkg::*;
();
    logic             valid;
    logic             ready;
    sample_t          left_out;
    sample_t          right_out;
    logic             was_empty;
    logic [OCC_W-1:0] frames_available;
    level_t           level_left;
    level_t           level_right;
    level_t           level_mean;

    modport source (output valid, left_out, right_out, was_empty, frames_available,
                    level_left, level_right, level_mean,
                    input ready);
    modport sink   (input valid, left_out, right_out, was_empty, frames_available,
                    level_left, level_right, level_mean,
                    output ready);
endinterface

>>> design/sspm_ring_mem.sv
module sspm_ring_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sspm_meter.sv
module sspm_meter
    import sspm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DECAY_W-1:0] decay_coeff,
    input  mtr_req_t           req,
    output level_t             level_left,
    output level_t             level_right
);

    level_t peak_l_reg, peak_l_next;
    level_t peak_r_reg, peak_r_next;
    level_t lvl_l_reg, lvl_l_next;
    level_t lvl_r_reg, lvl_r_next;
    level_t abs_l, abs_r;
    logic [LEVEL_W+DECAY_W-1:0] prod_l, prod_r;
    level_t dec_l, dec_r;

    always_comb
    begin
        abs_l  = abs_sat(req.left);
        abs_r  = abs_sat(req.right);
        prod_l = (LEVEL_W+DECAY_W)'(lvl_l_reg) * (LEVEL_W+DECAY_W)'(decay_coeff);
        prod_r = (LEVEL_W+DECAY_W)'(lvl_r_reg) * (LEVEL_W+DECAY_W)'(decay_coeff);
        dec_l  = prod_l[LEVEL_W+DECAY_W-1:DECAY_W];
        dec_r  = prod_r[LEVEL_W+DECAY_W-1:DECAY_W];

        peak_l_next = peak_l_reg;
        peak_r_next = peak_r_reg;
        lvl_l_next  = lvl_l_reg;
        lvl_r_next  = lvl_r_reg;
        if (req.wr)
        begin
            if (abs_l > peak_l_reg)
                peak_l_next = abs_l;
            if (abs_r > peak_r_reg)
                peak_r_next = abs_r;
        end
        else if (req.eob)
        begin
            lvl_l_next  = (peak_l_reg > dec_l) ? peak_l_reg : dec_l;
            lvl_r_next  = (peak_r_reg > dec_r) ? peak_r_reg : dec_r;
            peak_l_next = '0;
            peak_r_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_l_reg <= '0;
            peak_r_reg <= '0;
            lvl_l_reg  <= '0;
            lvl_r_reg  <= '0;
        end
        else
        begin
            peak_l_reg <= peak_l_next;
            peak_r_reg <= peak_r_next;
            lvl_l_reg  <= lvl_l_next;
            lvl_r_reg  <= lvl_r_next;
        end
    end

    assign level_left  = lvl_l_reg;
    assign level_right = lvl_r_reg;

endmodule

>>> design/stereo_sample_fifo_peak_meter.sv
// An accepted word is held in stage 1, then moves to the output register, from which it is offered on rsp.
// One word per cycle while rsp.ready does not stall; the ring memory's registered read sets the latency.
// A word is accepted while a finished result still waits in the output register, if stage 1 is empty.
// Reset (rst_n, async low) clears pointers, peaks, levels and valid flags and loads
// ring_frames 4096 (clamped to RING_DEPTH) and decay 0.85; ring contents stay unset.
module stereo_sample_fifo_peak_meter
    import sspm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sspm_req_if.sink              req,
    sspm_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int SZ_W   = $clog2(RING_DEPTH + 1);
    localparam int SZ_RST = (RING_FRAMES_RST < RING_DEPTH) ? RING_FRAMES_RST : RING_DEPTH;

    logic [SZ_W-1:0]    size_reg, size_next;
    logic [DECAY_W-1:0] decay_reg, decay_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_rd_ok_reg, s1_rd_ok_next;
    logic s1_empty_reg, s1_empty_next;

    logic             out_valid_reg, out_valid_next;
    sample_t          out_left_reg, out_left_next;
    sample_t          out_right_reg, out_right_next;
    logic             out_empty_reg, out_empty_next;
    logic [OCC_W-1:0] out_occ_reg, out_occ_next;
    level_t           out_lvl_l_reg, out_lvl_l_next;
    level_t           out_lvl_r_reg, out_lvl_r_next;
    level_t           out_mean_reg, out_mean_next;

    logic                     s1_adv, accept, nonempty;
    logic                     do_wr, do_rd, do_eob;
    sample_t                  right_eff;
    logic [SZ_W-1:0]          wr_inc, rd_inc, wr_ext, rd_ext, occ, new_size;
    logic [OCC_W+SZ_W-1:0]    occ_ext;
    logic [31:0]              rf_wide;
    logic [2*SAMPLE_BITS-1:0] rdata;
    logic [LEVEL_W:0]         lvl_sum;
    level_t                   lvl_l, lvl_r;
    mtr_req_t                 mtr_req;

    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;
    assign nonempty  = (wr_ptr_reg != rd_ptr_reg);
    assign right_eff = req.is_mono ? req.left_sample : req.right_sample;

    always_comb
    begin
        do_wr  = 1'b0;
        do_rd  = 1'b0;
        do_eob = 1'b0;
        unique case (req.req_type)
            REQ_WRITE: do_wr  = accept;
            REQ_READ:  do_rd  = accept;
            REQ_EOB:   do_eob = accept;
            REQ_NOP:   ;
        endcase
    end

    // occupancy from the pointers: the state after the item in stage 1, unless a cfg write held the pointers
    always_comb
    begin
        wr_ext  = SZ_W'(wr_ptr_reg);
        rd_ext  = SZ_W'(rd_ptr_reg);
        wr_inc  = wr_ext + SZ_W'(1);
        rd_inc  = rd_ext + SZ_W'(1);
        if (wr_ext >= rd_ext)
            occ = wr_ext - rd_ext;
        else
            occ = size_reg - rd_ext + wr_ext;
        occ_ext = {{OCC_W{1'b0}}, occ};
        rf_wide = 32'(cfg_data[RING_FRAMES_W-1:0]);
        if (rf_wide < 32'd2)
            new_size = SZ_W'(2);
        else if (rf_wide > 32'(RING_DEPTH))
            new_size = SZ_W'(RING_DEPTH);
        else
            new_size = SZ_W'(rf_wide);
    end

    always_comb
    begin
        size_next   = size_reg;
        decay_next  = decay_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        priority if (cfg_we)
        begin
            if (cfg_index == CFG_RING_FRAMES)
            begin
                size_next = new_size;
                if (wr_ext >= new_size)
                    wr_ptr_next = '0;
                if (rd_ext >= new_size)
                    rd_ptr_next = '0;
            end
            else if (cfg_index == CFG_DECAY_COEFF)
            begin
                decay_next = cfg_data[DECAY_W-1:0];
            end
        end
        else
        begin
            if (do_wr)
                wr_ptr_next = (wr_inc >= size_reg) ? '0 : wr_inc[PTR_W-1:0];
            if (do_rd && nonempty)
                rd_ptr_next = (rd_inc >= size_reg) ? '0 : rd_inc[PTR_W-1:0];
        end
    end

    // write lands at the edge, so a read in the next cycle sees it
    sspm_ring_mem #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (2 * SAMPLE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (do_wr),
        .waddr (wr_ptr_reg),
        .wdata ({req.left_sample, right_eff}),
        .re    (do_rd && nonempty),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    assign mtr_req = '{wr: do_wr, eob: do_eob, left: req.left_sample, right: right_eff};

    sspm_meter u_meter (
        .clk         (clk),
        .rst_n       (rst_n),
        .decay_coeff (decay_reg),
        .req         (mtr_req),
        .level_left  (lvl_l),
        .level_right (lvl_r)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_rd_ok_next = s1_rd_ok_reg;
        s1_empty_next = s1_empty_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_rd_ok_next = do_rd && nonempty;
            s1_empty_next = do_rd && !nonempty;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // stage 1 leaves only on the edge a new word may enter, so status regs match it
    always_comb
    begin
        lvl_sum        = {1'b0, lvl_l} + {1'b0, lvl_r};
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_empty_next = out_empty_reg;
        out_occ_next   = out_occ_reg;
        out_lvl_l_next = out_lvl_l_reg;
        out_lvl_r_next = out_lvl_r_reg;
        out_mean_next  = out_mean_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            out_left_next  = s1_rd_ok_reg ? rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
            out_right_next = s1_rd_ok_reg ? rdata[SAMPLE_BITS-1:0] : '0;
            out_empty_next = s1_empty_reg;
            out_occ_next   = occ_ext[OCC_W-1:0];
            out_lvl_l_next = lvl_l;
            out_lvl_r_next = lvl_r;
            out_mean_next  = lvl_sum[LEVEL_W:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SZ_W'(SZ_RST);
            decay_reg     <= DECAY_RST;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            decay_reg     <= decay_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rd_ok_reg  <= s1_rd_ok_next;
        s1_empty_reg  <= s1_empty_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_empty_reg <= out_empty_next;
        out_occ_reg   <= out_occ_next;
        out_lvl_l_reg <= out_lvl_l_next;
        out_lvl_r_reg <= out_lvl_r_next;
        out_mean_reg  <= out_mean_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.left_out         = out_left_reg;
    assign rsp.right_out        = out_right_reg;
    assign rsp.was_empty        = out_empty_reg;
    assign rsp.frames_available = out_occ_reg;
    assign rsp.level_left       = out_lvl_l_reg;
    assign rsp.level_right      = out_lvl_r_reg;
    assign rsp.level_mean       = out_mean_reg;

endmodule
